// ===== rtl/skcs_pkg.sv =====
package skcs_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // Operation codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] key_value;
    logic        color_in;
    logic [5:0]  rank;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] key_out;
    logic        color_out;
    logic [6:0]  entry_total;
  } out_item_t;

  // Per-cycle commands that the controller broadcasts to every cell.
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } cell_ctrl_t;

endpackage

// ===== rtl/skcs_cell.sv =====
module skcs_cell
  import skcs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int INDEX    = 0
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic [KEY_BITS-1:0]           key_in,
  input  logic                          color_in,
  input  logic [5:0]                    rank,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic [KEY_BITS-1:0]           left_key,
  input  logic                          left_color,
  input  logic                          left_lt,
  output logic [KEY_BITS-1:0]           key_r,
  output logic                          color_r,
  output logic                          lt_r,
  output logic [KEY_BITS+2:0]           contrib_r
);

  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic                valid;
  logic                sel;
  logic                load_new;
  logic [KEY_BITS-1:0] key_nxt;
  logic                color_nxt;
  logic                lt_nxt;
  logic [KEY_BITS+2:0] contrib_nxt;

  assign valid    = CNT_W'(INDEX) < count;
  assign sel      = ({{IDX_W{1'b0}}, rank} == (IDX_W + 6)'(INDEX));
  // The first cell at or above the insertion point takes the new key;
  // every cell above it takes its left neighbor's entry.
  assign load_new = (INDEX == 0) || left_lt;

  always_comb begin
    lt_nxt      = valid && (key_r < key_in);
    contrib_nxt = {valid && (key_r == key_in),
                   valid && (key_r == key_in) && color_r,
                   sel ? key_r : {KEY_BITS{1'b0}},
                   sel && color_r};
    key_nxt     = key_r;
    color_nxt   = color_r;
    if (ctrl.upd_en && !lt_r) begin
      if (load_new) begin
        key_nxt   = key_in;
        color_nxt = color_in;
      end else begin
        key_nxt   = left_key;
        color_nxt = left_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    color_r <= color_nxt;
    if (ctrl.cmp_en) begin
      lt_r      <= lt_nxt;
      contrib_r <= contrib_nxt;
    end
  end

endmodule

// ===== rtl/skcs_reduce.sv =====
module skcs_reduce
  import skcs_pkg::*;
#(
  parameter int N = CAPACITY_DEF,
  parameter int W = KEY_BITS_DEF + 3
) (
  input  logic [N-1:0][W-1:0] data,
  output logic [W-1:0]        result
);

  // Each field of a contribution is nonzero in at most one cell, so an OR
  // merges them.
  always_comb begin
    result = '0;
    for (int i = 0; i < N; i++) begin
      result = result | data[i];
    end
  end

endmodule

// ===== rtl/sorted_key_color_set_insert_core.sv =====
// A transaction passes through S_CMP and then S_UPD; out_data and out_valid are registered.
// A new transaction can be accepted while in S_UPD; busy is high only in the compare
// cycle, set by the controller state register.
// Reset (rst_n low, synchronous) empties the table and drops any result in flight;
// stored keys are not cleared. The receiver cannot stall: out_valid pulses once.
module sorted_key_color_set_insert_core
  import skcs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int CON_W = KEY_BITS + 3;

  // Controller states: a transaction is latched, the cells compare in the next
  // cycle, and the cycle after that applies the update and forms the result.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  in_item_t   item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_item_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       accept;
  cell_ctrl_t ctrl;
  logic [KEY_BITS-1:0] key_ext;

  logic [CAPACITY-1:0][KEY_BITS-1:0] cell_key;
  logic [CAPACITY-1:0]               cell_color;
  logic [CAPACITY-1:0]               cell_lt;
  logic [CAPACITY-1:0][CON_W-1:0]    cell_contrib;
  logic [CON_W-1:0]                  merged;

  logic                found;
  logic                match_color;
  logic [KEY_BITS-1:0] read_key;
  logic                read_color;
  logic                in_range;
  logic                do_write;

  // Keys above KEY_BITS are dropped; narrower keys are zero-extended.
  assign key_ext = KEY_BITS'(item_r.key_value);

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;

  // The chain of cells: each holds one table entry and, on an insert, either
  // keeps its entry, takes the new key, or takes its left neighbor's entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic                left_color;
    logic                left_lt;
    if (i == 0) begin : g_first
      assign left_key   = '0;
      assign left_color = 1'b0;
      assign left_lt    = 1'b0;
    end else begin : g_rest
      assign left_key   = cell_key[i-1];
      assign left_color = cell_color[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    skcs_cell #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key_in     (key_ext),
      .color_in   (item_r.color_in),
      .rank       (item_r.rank),
      .count      (count_r),
      .left_key   (left_key),
      .left_color (left_color),
      .left_lt    (left_lt),
      .key_r      (cell_key[i]),
      .color_r    (cell_color[i]),
      .lt_r       (cell_lt[i]),
      .contrib_r  (cell_contrib[i])
    );
  end

  skcs_reduce #(
    .N (CAPACITY),
    .W (CON_W)
  ) u_reduce (
    .data   (cell_contrib),
    .result (merged)
  );

  assign found       = merged[CON_W-1];
  assign match_color = merged[CON_W-2];
  assign read_key    = merged[KEY_BITS:1];
  assign read_color  = merged[0];
  assign in_range    = CMP_W'(item_r.rank) < CMP_W'(count_r);

  // A new key is written only when it is absent and there is room for it.
  assign do_write = (state_r == S_UPD) && (item_r.cmd == CMD_INSERT) && !found &&
                    (count_r != CNT_W'(CAPACITY));

  assign ctrl.cmp_en = (state_r == S_CMP);
  assign ctrl.upd_en = do_write;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt         = accept ? S_CMP : S_IDLE;
        out_valid_nxt     = 1'b1;
        out_nxt.key_out   = '0;
        out_nxt.color_out = 1'b0;
        if (item_r.cmd == CMD_INSERT) begin
          if (found) begin
            out_nxt.status = (match_color == item_r.color_in) ? ST_OK : ST_CONFLICT;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            out_nxt.status = ST_FULL;
          end else begin
            out_nxt.status = ST_OK;
            count_nxt      = count_r + CNT_W'(1);
          end
        end else if (in_range) begin
          out_nxt.status    = ST_OK;
          out_nxt.key_out   = 16'(read_key);
          out_nxt.color_out = read_color;
        end else begin
          out_nxt.status = ST_RANGE;
        end
        out_nxt.entry_total = 7'(count_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The transaction register and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
